[hw/rtl/chd_pkg.sv]
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants of the chunked transfer decoder
// Holds the transaction structs, status codes, delimiter characters and
// the hex digit decode used by the parser; the checker uses the status codes.
// ----------------------------------------------------------------------------
package chd_pkg;

    // Operation codes of an input transaction
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Status codes of a result transaction
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    // Delimiter characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Hex digit characters
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [1:0] status;
        logic       byte_ignored;
    } out_item_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    // Decode one character as a hex digit in either case
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        logic [7:0] diff;
        r    = '0;
        diff = '0;
        if (c >= CH_0 && c <= CH_9)
        begin
            diff    = c - CH_0;
            r.ok    = 1'b1;
            r.value = diff[3:0];
        end
        else if (c >= CH_LOW_A && c <= CH_LOW_F)
        begin
            diff    = c - CH_LOW_A + 8'd10;
            r.ok    = 1'b1;
            r.value = diff[3:0];
        end
        else if (c >= CH_UP_A && c <= CH_UP_F)
        begin
            diff    = c - CH_UP_A + 8'd10;
            r.ok    = 1'b1;
            r.value = diff[3:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/chd_in_if.sv]
// ----------------------------------------------------------------------------
// chd_in_if: encoded stream channel
// Valid/ready channel carrying one stream byte or an end-of-input event.
// ----------------------------------------------------------------------------
interface chd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

[hw/rtl/chd_out_if.sv]
// ----------------------------------------------------------------------------
// chd_out_if: decoded result channel
// Valid/ready channel carrying one result per input transaction.
// ----------------------------------------------------------------------------
interface chd_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic       byte_ignored;

    modport source (output valid, output payload_valid, output payload_byte,
                    output status, output byte_ignored, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input status, input byte_ignored, output ready);
endinterface

[hw/rtl/http_chunked_decoder_top.sv]
// ----------------------------------------------------------------------------
// http_chunked_decoder_top: HTTP/1.1 chunked body decoder
// Decodes a chunked-encoded byte stream into content bytes and a status.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries one transaction per encoded byte (operation = byte) or
//   one end-of-input event (operation = end). Every stream transaction
//   yields exactly one result transaction on result, in order.
//   result.payload_valid marks chunk content in payload_byte; status reads
//   running, finished or error; byte_ignored flags a byte dropped after
//   finish or error. Error and finished are sticky until reset.
//   An accepted stream transaction passes through the input register, then
//   the framing state machine feeding the result register, before
//   result.valid rises. Throughput is one transaction per cycle while result
//   is not stalled; the phase / length update is one registered step
//   (shift-in of a hex digit or a length decrement).
//   Reset clears the phase to the first length digit, the length to zero
//   and both stage valids; the block is ready as soon as reset is released.
//   When result stalls, the result register holds, the input register
//   takes one more transaction, and stream.ready then drops.
// ----------------------------------------------------------------------------
module http_chunked_decoder_top
#(
    parameter int LEN_BITS = 63
)
(
    input  logic        clk,
    input  logic        rst_n,
    chd_in_if.sink      stream,
    chd_out_if.source   result
);

    chd_pkg::in_item_t  up_item;
    chd_pkg::in_item_t  item;
    chd_pkg::out_item_t res_item;
    logic               item_valid;
    logic               take;

    assign up_item.operation = stream.operation;
    assign up_item.data_byte = stream.data_byte;

    chd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (stream.valid),
        .up_ready   (stream.ready),
        .up_item    (up_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    chd_parser #(.LEN_BITS(LEN_BITS)) u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res_item   (res_item)
    );

    assign result.payload_valid = res_item.payload_valid;
    assign result.payload_byte  = res_item.payload_byte;
    assign result.status        = res_item.status;
    assign result.byte_ignored  = res_item.byte_ignored;

endmodule

[hw/rtl/chd_in_stage.sv]
// ----------------------------------------------------------------------------
// chd_in_stage: input register
// Captures one input transaction and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module chd_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  chd_pkg::in_item_t up_item,
    output logic              item_valid,
    output chd_pkg::in_item_t item,
    input  logic              take
);

    logic              valid_reg;
    logic              valid_next;
    chd_pkg::in_item_t item_reg;

    // Accept when empty or when the held transaction leaves this cycle
    assign up_ready   = !valid_reg || take;
    assign valid_next = (up_valid && up_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/chd_parser.sv]
// ----------------------------------------------------------------------------
// chd_parser: chunked framing state machine and result register
// Updates phase, chunk length and digit flag, one transaction per cycle while
// the result register is free or drains, and registers each result until taken.
// ----------------------------------------------------------------------------
module chd_parser
#(
    parameter int LEN_BITS = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  chd_pkg::in_item_t  item,
    output logic               take,
    output logic               res_valid,
    input  logic               res_ready,
    output chd_pkg::out_item_t res_item
);

    // Phase codes
    localparam logic [3:0] PH_LEN     = 4'd0;
    localparam logic [3:0] PH_LEN_LF  = 4'd1;
    localparam logic [3:0] PH_DATA    = 4'd2;
    localparam logic [3:0] PH_DATA_CR = 4'd3;
    localparam logic [3:0] PH_DATA_LF = 4'd4;
    localparam logic [3:0] PH_TR_CR1  = 4'd5;
    localparam logic [3:0] PH_TR_LF1  = 4'd6;
    localparam logic [3:0] PH_TR_CR2  = 4'd7;
    localparam logic [3:0] PH_TR_LF2  = 4'd8;
    localparam logic [3:0] PH_DONE    = 4'd9;
    localparam logic [3:0] PH_ERR     = 4'd10;

    logic [3:0]          phase_reg;
    logic [3:0]          phase_next;
    logic [LEN_BITS-1:0] rem_reg;
    logic [LEN_BITS-1:0] rem_next;
    logic [LEN_BITS-1:0] rem_dec;
    logic                have_digit_reg;
    logic                have_digit_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    chd_pkg::out_item_t  out_item_reg;
    chd_pkg::out_item_t  out_item_next;
    chd_pkg::hex_digit_t hex;
    logic                len_full;

    // Advance when the result register is free or being drained
    assign take = item_valid && (!out_valid_reg || res_ready);

    assign hex      = chd_pkg::hex_decode(item.data_byte);
    // Another digit overflows once any of the top four length bits is set
    assign len_full = rem_reg[LEN_BITS-1 -: 4] != 4'd0;
    assign rem_dec  = rem_reg - {{(LEN_BITS-1){1'b0}}, 1'b1};

    // Next state and result of one transaction
    always_comb
    begin
        phase_next      = phase_reg;
        rem_next        = rem_reg;
        have_digit_next = have_digit_reg;
        out_item_next   = '0;

        if (phase_reg == PH_DONE || phase_reg == PH_ERR)
        begin
            out_item_next.byte_ignored = (item.operation == chd_pkg::OP_BYTE);
        end
        else if (item.operation == chd_pkg::OP_END)
        begin
            phase_next = PH_ERR;
        end
        else
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (hex.ok)
                    begin
                        if (!have_digit_reg)
                        begin
                            rem_next        = {{(LEN_BITS-4){1'b0}}, hex.value};
                            have_digit_next = 1'b1;
                        end
                        else if (len_full)
                        begin
                            phase_next = PH_ERR;
                        end
                        else
                        begin
                            rem_next = {rem_reg[LEN_BITS-5:0], hex.value};
                        end
                    end
                    else if (item.data_byte == chd_pkg::CH_CR && have_digit_reg)
                    begin
                        phase_next = PH_LEN_LF;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_LEN_LF:
                begin
                    if (item.data_byte != chd_pkg::CH_LF)
                    begin
                        phase_next = PH_ERR;
                    end
                    else if (rem_reg != '0)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_TR_CR2;
                    end
                    have_digit_next = 1'b0;
                end
                PH_DATA:
                begin
                    out_item_next.payload_valid = 1'b1;
                    out_item_next.payload_byte  = item.data_byte;
                    rem_next                    = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_DATA_CR;
                    end
                end
                PH_DATA_CR:
                begin
                    phase_next = (item.data_byte == chd_pkg::CH_CR) ? PH_DATA_LF : PH_ERR;
                end
                PH_DATA_LF:
                begin
                    if (item.data_byte == chd_pkg::CH_LF)
                    begin
                        phase_next      = PH_LEN;
                        have_digit_next = 1'b0;
                        rem_next        = '0;
                    end
                    else
                    begin
                        phase_next = PH_ERR;
                    end
                end
                PH_TR_CR1:
                begin
                    phase_next = (item.data_byte == chd_pkg::CH_CR) ? PH_TR_LF1 : PH_TR_CR1;
                end
                PH_TR_LF1:
                begin
                    phase_next = (item.data_byte == chd_pkg::CH_LF) ? PH_TR_CR2 : PH_TR_CR1;
                end
                PH_TR_CR2:
                begin
                    phase_next = (item.data_byte == chd_pkg::CH_CR) ? PH_TR_LF2 : PH_TR_CR1;
                end
                PH_TR_LF2:
                begin
                    phase_next = (item.data_byte == chd_pkg::CH_LF) ? PH_DONE : PH_TR_CR1;
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
        end

        if (phase_next == PH_DONE)
        begin
            out_item_next.status = chd_pkg::ST_FINISHED;
        end
        else if (phase_next == PH_ERR)
        begin
            out_item_next.status = chd_pkg::ST_ERROR;
        end
        else
        begin
            out_item_next.status = chd_pkg::ST_RUNNING;
        end
    end

    assign out_valid_next = take || (out_valid_reg && !res_ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN;
            rem_reg        <= '0;
            have_digit_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg      <= phase_next;
                rem_reg        <= rem_next;
                have_digit_reg <= have_digit_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

endmodule

[hw/rtl/chd_checker.sv]
// ----------------------------------------------------------------------------
// chd_checker: port-level assertions of the chunked decoder
// Watches the result channel for sticky status and field consistency.
// ----------------------------------------------------------------------------
module chd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       payload_valid,
    input logic [7:0] payload_byte,
    input logic [1:0] status,
    input logic       byte_ignored
);

    logic res_fire;
    logic err_seen_reg;
    logic done_seen_reg;

    assign res_fire = res_valid && res_ready;

    // Remember terminal status seen on delivered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg  <= 1'b0;
            done_seen_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            err_seen_reg  <= err_seen_reg || (status == chd_pkg::ST_ERROR);
            done_seen_reg <= done_seen_reg || (status == chd_pkg::ST_FINISHED);
        end
    end

    a_terminal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (err_seen_reg || done_seen_reg) |->
            (err_seen_reg && status == chd_pkg::ST_ERROR) ||
            (done_seen_reg && status == chd_pkg::ST_FINISHED))
        else $error("terminal status changed after delivery");

    a_payload_running: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && payload_valid |-> status == chd_pkg::ST_RUNNING && !byte_ignored)
        else $error("content byte outside running status");

    a_ignored_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && byte_ignored |-> status != chd_pkg::ST_RUNNING && !payload_valid)
        else $error("byte dropped while running");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !payload_valid |-> payload_byte == 8'd0)
        else $error("payload byte set without payload_valid");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status) && $stable(payload_byte))
        else $error("stalled result changed");

endmodule

bind http_chunked_decoder_top chd_checker u_chd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .payload_valid (result.payload_valid),
    .payload_byte  (result.payload_byte),
    .status        (result.status),
    .byte_ignored  (result.byte_ignored)
);

[tb/tb_http_chunked_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_chunked_decoder_top: self-checking bench for the chunked decoder
// Drives chunk-framed byte streams into the decoder and checks every result
// transaction against a cycle-free model of the framing state machine. A
// short directed script opens the run. Random well-formed chunks with random
// content follow. One randomly chosen ending closes the stream: finish,
// trailer scan, empty or overflowing size, bad delimiter, early end of input
// or noise. Bytes and end events after that check the sticky status.
// ----------------------------------------------------------------------------
module tb_http_chunked_decoder_top;

    localparam int LEN_BITS     = 63;
    localparam int RANDOM_END   = 1150;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SCRIPT_LEN   = 16;

    localparam logic [62:0] LEN_MAX = '1;

    localparam chd_pkg::out_item_t NO_PAYLOAD = '{1'b0, 8'h00, chd_pkg::ST_RUNNING, 1'b0};

    // Framing phases of the decode model
    typedef enum logic [3:0] {
        SCAN_SIZE, SIZE_LF, BODY, BODY_CR, BODY_LF,
        TRL_CR1, TRL_LF1, TRL_CR2, TRL_LF2, DONE, FAILED
    } decode_phase_t;

    // Ways to close the stream
    typedef enum int {
        END_PLAIN, END_TRAILER, END_EMPTY_SIZE, END_OVERFLOW,
        END_BAD_DELIM, END_EOI_BODY, END_EOI_FRAMING, END_NOISE
    } finale_t;

    typedef struct packed {
        logic               op;
        logic [7:0]         data;
        logic               typed;
        chd_pkg::out_item_t res;
    } script_row_t;

    logic clk;
    logic rst_n;

    chd_in_if  stream_if ();
    chd_out_if result_if ();

    http_chunked_decoder_top #(.LEN_BITS(LEN_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if)
    );

    // Directed opening: leading zero sizes, extreme content bytes, CR as content
    script_row_t script [SCRIPT_LEN] = '{
        '{chd_pkg::OP_BYTE, chd_pkg::CH_0,        1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_0,        1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_0 + 8'd2, 1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_CR,       1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_LF,       1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, 8'h00,                1'b1,
          '{1'b1, 8'h00, chd_pkg::ST_RUNNING, 1'b0}},
        '{chd_pkg::OP_BYTE, 8'hFF,                1'b1,
          '{1'b1, 8'hFF, chd_pkg::ST_RUNNING, 1'b0}},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_CR,       1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_LF,       1'b1, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_0,        1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_0 + 8'd1, 1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_CR,       1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_LF,       1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_CR,       1'b1,
          '{1'b1, chd_pkg::CH_CR, chd_pkg::ST_RUNNING, 1'b0}},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_CR,       1'b0, NO_PAYLOAD},
        '{chd_pkg::OP_BYTE, chd_pkg::CH_LF,       1'b0, NO_PAYLOAD}
    };

    // Decode model state
    decode_phase_t parse_phase = SCAN_SIZE;
    logic [62:0]   chunk_left  = '0;
    logic          size_seen   = 1'b0;

    chd_pkg::out_item_t decoded_results [$];
    logic [7:0]         frame_bytes [$];
    int                 delim_spots [$];

    logic               row_typed;
    chd_pkg::out_item_t row_result;
    bit                 calm = 1'b0;
    int unsigned        rdy_hold = 0;
    int                 items_sent = 0;
    int                 results_seen = 0;
    int                 mismatch_count = 0;
    int                 cycle_count = 0;

    // Advance the framing model by one transaction and return its result
    function automatic chd_pkg::out_item_t chunk_parse_step(input logic op,
                                                            input logic [7:0] c);
        chd_pkg::out_item_t r;
        logic               is_hex;
        logic [7:0]         lower;
        logic [62:0]        digit;
        r      = NO_PAYLOAD;
        is_hex = 1'b1;
        lower  = c | 8'h20;
        digit  = '0;
        if (c >= chd_pkg::CH_0 && c <= chd_pkg::CH_9)
            digit = 63'(c - chd_pkg::CH_0);
        else if (lower >= chd_pkg::CH_LOW_A && lower <= chd_pkg::CH_LOW_F)
            digit = 63'(lower - chd_pkg::CH_LOW_A + 8'd10);
        else
            is_hex = 1'b0;

        if (parse_phase == DONE || parse_phase == FAILED)
            r.byte_ignored = (op == chd_pkg::OP_BYTE);
        else if (op == chd_pkg::OP_END)
            parse_phase = FAILED;
        else
        begin
            case (parse_phase)
                SCAN_SIZE:
                begin
                    if (is_hex && !size_seen)
                    begin
                        chunk_left = digit;
                        size_seen  = 1'b1;
                    end
                    else if (is_hex)
                    begin
                        if (((LEN_MAX - digit) >> 4) < chunk_left)
                            parse_phase = FAILED;
                        else
                            chunk_left = (chunk_left << 4) | digit;
                    end
                    else if (c == chd_pkg::CH_CR && size_seen)
                        parse_phase = SIZE_LF;
                    else
                        parse_phase = FAILED;
                end
                SIZE_LF:
                begin
                    if (c != chd_pkg::CH_LF)
                        parse_phase = FAILED;
                    else if (chunk_left != '0)
                        parse_phase = BODY;
                    else
                        parse_phase = TRL_CR2;
                    size_seen = 1'b0;
                end
                BODY:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = c;
                    chunk_left      = chunk_left - 1'b1;
                    if (chunk_left == '0)
                        parse_phase = BODY_CR;
                end
                BODY_CR: parse_phase = (c == chd_pkg::CH_CR) ? BODY_LF : FAILED;
                BODY_LF:
                begin
                    if (c == chd_pkg::CH_LF)
                    begin
                        parse_phase = SCAN_SIZE;
                        size_seen   = 1'b0;
                        chunk_left  = '0;
                    end
                    else
                        parse_phase = FAILED;
                end
                TRL_CR1: parse_phase = (c == chd_pkg::CH_CR) ? TRL_LF1 : TRL_CR1;
                TRL_LF1: parse_phase = (c == chd_pkg::CH_LF) ? TRL_CR2 : TRL_CR1;
                TRL_CR2: parse_phase = (c == chd_pkg::CH_CR) ? TRL_LF2 : TRL_CR1;
                TRL_LF2: parse_phase = (c == chd_pkg::CH_LF) ? DONE : TRL_CR1;
                default: parse_phase = FAILED;
            endcase
        end

        if (parse_phase == DONE)
            r.status = chd_pkg::ST_FINISHED;
        else if (parse_phase == FAILED)
            r.status = chd_pkg::ST_ERROR;
        else
            r.status = chd_pkg::ST_RUNNING;
        return r;
    endfunction

    // Hex digit character in a random case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return chd_pkg::CH_0 + v;
        return ($urandom_range(0, 1) ? chd_pkg::CH_UP_A : chd_pkg::CH_LOW_A) + v - 8'd10;
    endfunction

    // Content byte, biased toward the delimiter characters
    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 9))
            0: return chd_pkg::CH_CR;
            1: return chd_pkg::CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 16);
        if (r < 98)
            return $urandom_range(17, 300);
        return $urandom_range(768, 1280);
    endfunction

    // Append a size field, sometimes with leading zeros
    task automatic add_size(input logic [62:0] n);
        logic [63:0] wide;
        int          top;
        wide = {1'b0, n};
        top  = 15;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 20)) frame_bytes.push_back(chd_pkg::CH_0);
        while (top > 0 && wide[top*4 +: 4] == 4'h0)
            top--;
        for (int i = top; i >= 0; i--)
            frame_bytes.push_back(hex_char(wide[i*4 +: 4]));
    endtask

    task automatic add_delim(input logic [7:0] ch);
        delim_spots.push_back(frame_bytes.size());
        frame_bytes.push_back(ch);
    endtask

    task automatic add_chunk(input int n);
        add_size(63'(n));
        add_delim(chd_pkg::CH_CR);
        add_delim(chd_pkg::CH_LF);
        repeat (n) frame_bytes.push_back(body_byte());
        add_delim(chd_pkg::CH_CR);
        add_delim(chd_pkg::CH_LF);
    endtask

    task automatic add_terminator();
        add_size('0);
        add_delim(chd_pkg::CH_CR);
        add_delim(chd_pkg::CH_LF);
        add_delim(chd_pkg::CH_CR);
        add_delim(chd_pkg::CH_LF);
    endtask

    // Present one transaction and hold it until it is accepted
    task automatic drive_item(input logic op, input logic [7:0] b,
                              input logic typed, input chd_pkg::out_item_t res);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            stream_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.operation <= op;
        stream_if.data_byte <= b;
        row_typed           <= typed;
        row_result          <= res;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            drive_item(chd_pkg::OP_BYTE, frame_bytes[i], 1'b0, NO_PAYLOAD);
        frame_bytes.delete();
        delim_spots.delete();
    endtask

    task automatic log_mismatch(input string why, input chd_pkg::out_item_t want,
                                input chd_pkg::out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"result %0d %s: expected valid=%0b byte=%02h status=%0d ",
                      "ignored=%0b, got valid=%0b byte=%02h status=%0d ignored=%0b"},
                     results_seen, why, want.payload_valid, want.payload_byte,
                     want.status, want.byte_ignored, got.payload_valid,
                     got.payload_byte, got.status, got.byte_ignored);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the result side in short bursts
    always @(posedge clk)
    begin
        if (rdy_hold != 0)
        begin
            rdy_hold        <= rdy_hold - 1;
            result_if.ready <= (rdy_hold == 1);
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            rdy_hold        <= $urandom_range(1, 5);
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= 1'b1;
    end

    // Check each result, then model each accepted stream transaction
    always @(posedge clk)
    begin : check_results
        chd_pkg::out_item_t got;
        chd_pkg::out_item_t want;
        chd_pkg::out_item_t calc;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                got = '{result_if.payload_valid, result_if.payload_byte,
                        result_if.status, result_if.byte_ignored};
                if (decoded_results.size() == 0)
                    log_mismatch("with nothing pending", NO_PAYLOAD, got);
                else
                begin
                    want = decoded_results.pop_front();
                    if (got.payload_valid !== want.payload_valid ||
                        got.payload_byte  !== want.payload_byte  ||
                        got.status        !== want.status        ||
                        got.byte_ignored  !== want.byte_ignored)
                        log_mismatch("mismatch", want, got);
                end
                results_seen++;
            end
            if (stream_if.valid && stream_if.ready)
            begin
                calc = chunk_parse_step(stream_if.operation, stream_if.data_byte);
                decoded_results.push_back(row_typed ? row_result : calc);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_http_chunked_decoder_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        finale_t     finale;
        int          idx;
        int          extra;
        int          body_len;
        logic [7:0]  orig;
        logic [7:0]  wrong;
        logic [62:0] big;

        stream_if.valid     <= 1'b0;
        stream_if.operation <= chd_pkg::OP_BYTE;
        stream_if.data_byte <= 8'h00;
        row_typed           <= 1'b0;
        row_result          <= NO_PAYLOAD;
        rst_n               <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed script
        for (int i = 0; i < SCRIPT_LEN; i++)
            drive_item(script[i].op, script[i].data, script[i].typed, script[i].res);

        // Random well-formed chunks, trimmed to the remaining item budget
        while (items_sent < RANDOM_END)
        begin
            body_len = pick_len();
            if (body_len > RANDOM_END - items_sent)
                body_len = RANDOM_END - items_sent;
            add_chunk(body_len);
            send_frame();
        end

        // Close the stream one way, with no idling from here on
        calm <= 1'b1;
        finale = finale_t'($urandom_range(0, 7));
        case (finale)
            END_PLAIN: add_terminator();
            END_TRAILER:
            begin
                add_size('0);
                frame_bytes.push_back(chd_pkg::CH_CR);
                frame_bytes.push_back(chd_pkg::CH_LF);
                repeat ($urandom_range(3, 30))
                begin
                    case ($urandom_range(0, 3))
                        0: frame_bytes.push_back(chd_pkg::CH_CR);
                        1: frame_bytes.push_back(chd_pkg::CH_LF);
                        default: frame_bytes.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                frame_bytes.push_back(chd_pkg::CH_CR);
                frame_bytes.push_back(chd_pkg::CH_LF);
                frame_bytes.push_back(chd_pkg::CH_CR);
                frame_bytes.push_back(chd_pkg::CH_LF);
            end
            END_EMPTY_SIZE: frame_bytes.push_back(chd_pkg::CH_CR);
            END_OVERFLOW:
            begin
                extra = 1;
                case ($urandom_range(0, 2))
                    0: big = LEN_MAX;
                    1:
                    begin
                        big[31:0]  = $urandom;
                        big[62:32] = 31'($urandom);
                        big[59]    = 1'b1;
                    end
                    default:
                    begin
                        // last digit that still fits, then one too many
                        big   = {4'h0, {59{1'b1}}};
                        extra = 2;
                    end
                endcase
                add_size(big);
                repeat (extra) frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            END_BAD_DELIM:
            begin
                add_chunk($urandom_range(1, 6));
                add_terminator();
                idx   = delim_spots[$urandom_range(0, delim_spots.size() - 1)];
                orig  = frame_bytes[idx];
                wrong = 8'($urandom_range(0, 255));
                while (wrong == orig)
                    wrong = 8'($urandom_range(0, 255));
                frame_bytes[idx] = wrong;
            end
            END_EOI_BODY:
            begin
                if ($urandom_range(0, 1))
                    big = LEN_MAX;
                else
                    big = 63'($urandom_range(1, 40));
                add_size(big);
                frame_bytes.push_back(chd_pkg::CH_CR);
                frame_bytes.push_back(chd_pkg::CH_LF);
                if (big > 16)
                    extra = $urandom_range(0, 15);
                else
                    extra = $urandom_range(0, int'(big) - 1);
                repeat (extra) frame_bytes.push_back(body_byte());
            end
            END_EOI_FRAMING:
            begin
                add_chunk($urandom_range(1, 4));
                add_terminator();
                idx = $urandom_range(0, frame_bytes.size() - 1);
                while (frame_bytes.size() > idx)
                    frame_bytes.pop_back();
            end
            default:
            begin
                repeat ($urandom_range(1, 40))
                begin
                    case ($urandom_range(0, 5))
                        0, 1: frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
                        2: frame_bytes.push_back(chd_pkg::CH_CR);
                        3: frame_bytes.push_back(chd_pkg::CH_LF);
                        default: frame_bytes.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        endcase
        send_frame();

        // End of input, then late bytes and events against the sticky status
        drive_item(chd_pkg::OP_END, 8'($urandom_range(0, 255)), 1'b0, NO_PAYLOAD);
        repeat (30)
            drive_item(($urandom_range(0, 3) == 0) ? chd_pkg::OP_END : chd_pkg::OP_BYTE,
                       8'($urandom_range(0, 255)), 1'b0, NO_PAYLOAD);
        stream_if.valid <= 1'b0;

        // Drain outstanding results
        while (decoded_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_http_chunked_decoder_top: PASS");
        else
            $display("tb_http_chunked_decoder_top: FAIL");
        $finish;
    end

endmodule

[http_chunked_decoder_top.f]
hw/rtl/chd_pkg.sv
hw/rtl/chd_in_if.sv
hw/rtl/chd_out_if.sv
hw/rtl/chd_in_stage.sv
hw/rtl/chd_parser.sv
hw/rtl/http_chunked_decoder_top.sv
hw/rtl/chd_checker.sv
tb/tb_http_chunked_decoder_top.sv
